// ----- sv/sbrc_pkg.sv -----
package sbrc_pkg;

  localparam int BLOCK_CNT_DEF  = 1024;
  localparam int INDEX_BITS_DEF = 32;
  localparam int OUT_DEPTH      = 4;

  localparam int CMD_W = 2;
  localparam int LOG_W = 5;
  localparam int SEL_W = 10;
  localparam int NNZ_W = 32;
  localparam int ROW_W = 16;
  localparam int LEN_W = 32;

  localparam logic [LOG_W-1:0] LOG_RESET = 5'd12;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_CLOSE,
    OP_READ,
    OP_CLEAR
  } op_kind_t;

  typedef struct packed {
    logic [ROW_W-1:0] single;
    logic [ROW_W-1:0] rows;
    logic [NNZ_W-1:0] nnz;
  } entry_t;

  typedef struct packed {
    op_kind_t         kind;
    logic             blank;
    logic             err;
    logic [LEN_W-1:0] len;
  } op_t;

  typedef struct packed {
    logic   err;
    entry_t cnt;
  } result_t;

endpackage

// ----- sv/sbrc_run_tracker.sv -----
module sbrc_run_tracker #(
  parameter int BLOCK_CNT  = sbrc_pkg::BLOCK_CNT_DEF,
  parameter int INDEX_BITS = sbrc_pkg::INDEX_BITS_DEF,
  parameter int ADDR_W     = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [sbrc_pkg::LOG_W-1:0]   col_block_log,
  input  logic                         in_valid,
  input  sbrc_pkg::cmd_t               in_cmd,
  input  logic [INDEX_BITS-1:0]        col_index,
  input  logic                         row_last,
  input  logic [sbrc_pkg::SEL_W-1:0]   block_select,
  output sbrc_pkg::op_t                op,
  output logic [ADDR_W-1:0]            op_addr,
  output logic                         pend_busy
);
  import sbrc_pkg::*;

  localparam int CMP_W = INDEX_BITS + 17;

  logic                  run_open;
  logic                  pend_valid;
  logic                  err_sticky;
  logic [INDEX_BITS-1:0] cur_block;
  logic [LEN_W-1:0]      run_len;
  logic                  cur_ok;
  logic [ADDR_W-1:0]     pend_addr;
  logic [LEN_W-1:0]      pend_len;

  logic [INDEX_BITS-1:0] bid;
  logic                  bid_ok;
  logic                  sel_ok;
  logic                  same;
  logic [LEN_W-1:0]      len_next;
  logic                  add_item;

  assign bid      = col_index >> col_block_log;
  assign bid_ok   = CMP_W'(bid) < CMP_W'(BLOCK_CNT);
  assign sel_ok   = CMP_W'(block_select) < CMP_W'(BLOCK_CNT);
  assign same     = run_open && (bid == cur_block);
  assign len_next = same ? run_len + LEN_W'(1) : LEN_W'(1);
  assign add_item = in_valid && (in_cmd == CMD_ADD);
  assign pend_busy = pend_valid;

  always_comb begin
    op.kind  = OP_NONE;
    op.blank = 1'b0;
    op.err   = err_sticky;
    op.len   = pend_len;
    op_addr  = pend_addr;
    if (pend_valid) begin
      op.kind = OP_CLOSE;
    end else if (in_valid) begin
      case (in_cmd)
        CMD_ADD: begin
          if (run_open && !same && cur_ok) begin
            op.kind = OP_CLOSE;
            op.len  = run_len;
            op_addr = ADDR_W'(cur_block);
          end
        end
        CMD_READ: begin
          op.kind  = OP_READ;
          op.blank = !sel_ok;
          op_addr  = ADDR_W'(block_select);
        end
        CMD_CLEAR: begin
          if (sel_ok) begin
            op.kind = OP_CLEAR;
            op_addr = ADDR_W'(block_select);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_open   <= 1'b0;
      pend_valid <= 1'b0;
      err_sticky <= 1'b0;
    end else begin
      pend_valid <= 1'b0;
      if (add_item) begin
        if (!bid_ok) begin
          err_sticky <= 1'b1;
        end
        if (row_last) begin
          run_open   <= 1'b0;
          pend_valid <= bid_ok;
        end else begin
          run_open <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (add_item) begin
      cur_block <= bid;
      run_len   <= len_next;
      cur_ok    <= bid_ok;
      pend_addr <= ADDR_W'(bid);
      pend_len  <= len_next;
    end
  end

  a_pend_closed: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> !run_open)
    else $error("pending run while a run is open");

  a_no_cmd_over_pend: assert property (@(posedge clk) disable iff (rst)
    pend_valid && in_valid |-> in_cmd != CMD_READ && in_cmd != CMD_CLEAR)
    else $error("read or clear accepted over a pending close");

  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    err_sticky |=> err_sticky)
    else $error("range error flag dropped");

endmodule

// ----- sv/sbrc_counter_mem.sv -----
module sbrc_counter_mem #(
  parameter int BLOCK_CNT  = sbrc_pkg::BLOCK_CNT_DEF,
  parameter int ADDR_W     = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sbrc_pkg::op_t        op,
  input  logic [ADDR_W-1:0]    op_addr,
  output logic                 busy,
  output logic                 rd_busy,
  output logic                 res_valid,
  output sbrc_pkg::result_t    res
);
  import sbrc_pkg::*;

  entry_t            mem [BLOCK_CNT];
  entry_t            rd_data;
  op_t               s1_op;
  logic [ADDR_W-1:0] s1_addr;
  logic              clearing;
  logic [ADDR_W-1:0] clr_idx;
  logic              fwd_en;
  logic [ADDR_W-1:0] fwd_addr;
  entry_t            fwd_data;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  entry_t            wr_data;
  entry_t            cur;

  assign busy      = clearing;
  assign rd_busy   = (s1_op.kind == OP_READ);
  assign cur       = (fwd_en && fwd_addr == s1_addr) ? fwd_data : rd_data;
  assign res_valid = (s1_op.kind == OP_READ);
  assign res.err   = s1_op.err;
  assign res.cnt   = s1_op.blank ? '0 : cur;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = s1_addr;
    wr_data = '0;
    if (clearing) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx;
    end else begin
      case (s1_op.kind)
        OP_CLOSE: begin
          wr_en          = 1'b1;
          wr_data.nnz    = cur.nnz + s1_op.len;
          wr_data.rows   = cur.rows + ROW_W'(1);
          wr_data.single = cur.single + ROW_W'(s1_op.len == LEN_W'(1));
        end
        OP_CLEAR: wr_en = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[op_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
      s1_op    <= '0;
      fwd_en   <= 1'b0;
    end else begin
      s1_op  <= op;
      fwd_en <= wr_en;
      if (clearing) begin
        if (clr_idx == ADDR_W'(BLOCK_CNT - 1)) begin
          clearing <= 1'b0;
        end else begin
          clr_idx <= clr_idx + ADDR_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_addr  <= op_addr;
    fwd_addr <= wr_addr;
    fwd_data <= wr_data;
  end

  a_idle_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> op.kind == OP_NONE)
    else $error("table access during clearing pass");

  a_sweep_complete: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> $past(clr_idx) == ADDR_W'(BLOCK_CNT - 1))
    else $error("clearing pass ended early");

  a_clear_then_read: assert property (@(posedge clk) disable iff (rst)
    (op.kind == OP_CLEAR ##1 op.kind == OP_READ && op_addr == $past(op_addr))
    |=> res_valid && res.cnt == '0)
    else $error("read after clear missed forwarded value");

endmodule

// ----- sv/sbrc_out_fifo.sv -----
module sbrc_out_fifo #(
  parameter int DEPTH = sbrc_pkg::OUT_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sbrc_pkg::result_t   din,
  input  logic                reserve,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output sbrc_pkg::result_t   dout
);
  import sbrc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  result_t            buf_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign dout      = buf_q[rd_ptr];
  assign room      = ({1'b0, count} + (CNT_W + 1)'(reserve)) < (CNT_W + 1)'(DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_q[wr_ptr] <= din;
    end
  end

endmodule

// ----- sv/sparse_block_run_counter_top.sv -----
// Read word: the result is registered in the table read stage and then in the output FIFO before it appears on m_axis.
// Throughput: one word per cycle while s_axis_tready is high; a read or clear right
// after a row-ending word waits while that row's last run is written back to the table.
// Output side buffers four results; s_axis holds off when they are all claimed.
// Reset: col_block_log returns to 12, run state and error flag clear, and the
// table is zeroed entry by entry with s_axis_tready low.
module sparse_block_run_counter_top #(
  parameter int BLOCK_CNT  = sbrc_pkg::BLOCK_CNT_DEF,
  parameter int INDEX_BITS = sbrc_pkg::INDEX_BITS_DEF,
  localparam int S_DATA_W  = ((INDEX_BITS + sbrc_pkg::SEL_W + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [sbrc_pkg::LOG_W-1:0]         cfg_wdata,     // col_block_log
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [S_DATA_W-1:0]                s_axis_tdata,  // col_index, block_select
  input  logic                               s_axis_tlast,  // row_last
  input  logic [sbrc_pkg::CMD_W-1:0]         s_axis_tuser,  // cmd
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [$bits(sbrc_pkg::entry_t)-1:0] m_axis_tdata, // nonzero_count, row_count,
                                                            // single_row_count
  output logic [0:0]                         m_axis_tuser   // range_error
);
  import sbrc_pkg::*;

  localparam int ADDR_W = (BLOCK_CNT > 1) ? $clog2(BLOCK_CNT) : 1;

  logic [LOG_W-1:0]      col_block_log;
  logic [INDEX_BITS-1:0] col_index;
  logic [SEL_W-1:0]      block_select;
  cmd_t                  cmd;
  logic                  accept;
  logic                  stall;
  logic                  pend_busy;
  logic                  busy;
  logic                  rd_busy;
  logic                  room;
  op_t                   op;
  logic [ADDR_W-1:0]     op_addr;
  logic                  res_valid;
  result_t               res;
  result_t               out_word;

  assign col_index     = s_axis_tdata[INDEX_BITS-1:0];
  assign block_select  = s_axis_tdata[INDEX_BITS +: SEL_W];
  assign cmd           = cmd_t'(s_axis_tuser);
  assign stall         = pend_busy && (cmd == CMD_READ || cmd == CMD_CLEAR);
  assign s_axis_tready = !busy && room && !stall;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata  = out_word.cnt;
  assign m_axis_tuser  = out_word.err;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_block_log <= LOG_RESET;
    end else if (cfg_we) begin
      col_block_log <= cfg_wdata;
    end
  end

  sbrc_run_tracker #(
    .BLOCK_CNT  (BLOCK_CNT),
    .INDEX_BITS (INDEX_BITS),
    .ADDR_W     (ADDR_W)
  ) u_tracker (
    .clk           (clk),
    .rst           (rst),
    .col_block_log (col_block_log),
    .in_valid      (accept),
    .in_cmd        (cmd),
    .col_index     (col_index),
    .row_last      (s_axis_tlast),
    .block_select  (block_select),
    .op            (op),
    .op_addr       (op_addr),
    .pend_busy     (pend_busy)
  );

  sbrc_counter_mem #(
    .BLOCK_CNT  (BLOCK_CNT),
    .ADDR_W     (ADDR_W)
  ) u_mem (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .op_addr   (op_addr),
    .busy      (busy),
    .rd_busy   (rd_busy),
    .res_valid (res_valid),
    .res       (res)
  );

  sbrc_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .din       (res),
    .reserve   (rd_busy),
    .room      (room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .dout      (out_word)
  );

endmodule
